// File: hdl/jlsmp_pkg.sv
// Package with the marker codes, parse phases and result type of the JPEG-LS header parser.
`default_nettype none

package jlsmp_pkg;

    localparam logic [7:0] MARK_BYTE = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_SOF    = 8'hF7;
    localparam logic [7:0] MK_SOS    = 8'hDA;
    localparam logic [7:0] MK_LSE    = 8'hF8;
    localparam logic [7:0] MK_COM    = 8'hFE;

    localparam logic [7:0] LSE_KIND_PRESET = 8'd1;
    localparam int         PRESET_COUNT    = 5;

    localparam logic [15:0] NEED_SOF      = 16'd8;
    localparam logic [15:0] NEED_SOS      = 16'd5;
    localparam logic [15:0] NEED_LSE      = 16'd3;
    localparam logic [15:0] NEED_COM      = 16'd2;
    localparam logic [15:0] NEED_PRESET   = 16'd13;
    localparam logic [15:0] LAST_PRESET_B = 16'd10;

    typedef enum logic [6:0] {
        PH_SOI_FF  = 7'b0000001,
        PH_SOI     = 7'b0000010,
        PH_MARK_FF = 7'b0000100,
        PH_MARKER  = 7'b0001000,
        PH_LEN_HI  = 7'b0010000,
        PH_LEN_LO  = 7'b0100000,
        PH_BODY    = 7'b1000000
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_INVALID     = 2'd1,
        ST_UNSUPPORTED = 2'd2,
        ST_SHORT       = 2'd3
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [7:0]  sample_bits;
        logic [15:0] image_height;
        logic [15:0] image_width;
        logic [7:0]  component_count;
        logic [7:0]  near_limit;
        logic [7:0]  interleave_mode;
        logic [15:0] max_sample;
        logic [15:0] threshold_one;
        logic [15:0] threshold_two;
        logic [15:0] threshold_three;
        logic [15:0] reset_interval;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/jlsmp_core.sv
// Parser state and the per-byte step logic of the JPEG-LS header parser.
`default_nettype none

module jlsmp_core (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  wire  [7:0]            i_byte,
    output logic                  o_res_valid,
    output jlsmp_pkg::t_result    o_res
);
    import jlsmp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_marker, n_marker;
    logic [15:0] r_len, n_len;
    logic [15:0] r_pos, n_pos;
    logic [7:0]  r_high, n_high;
    logic [7:0]  r_scomp, n_scomp;
    logic [7:0]  r_kind, n_kind;
    logic [47:0] r_frame, n_frame;
    logic [15:0] r_scan, n_scan;
    logic [15:0] r_preset [PRESET_COUNT];
    logic [15:0] n_preset [PRESET_COUNT];

    logic        clear;
    logic        advance;
    logic [15:0] len_word;
    logic [15:0] need;
    logic [16:0] sos_need;
    logic [16:0] near_pos;
    logic [16:0] mode_pos;
    logic [15:0] pos_next;
    logic [2:0]  preset_idx;

    assign len_word   = {r_high, i_byte};
    assign sos_need   = 17'd5 + {8'd0, i_byte, 1'b0};
    assign near_pos   = 17'd1 + {8'd0, r_scomp, 1'b0};
    assign mode_pos   = 17'd2 + {8'd0, r_scomp, 1'b0};
    assign pos_next   = r_pos + 16'd1;
    assign preset_idx = r_pos[3:1] - 3'd1;

    always_comb begin
        priority if (r_marker == MK_SOF) begin
            need = NEED_SOF;
        end else if (r_marker == MK_SOS) begin
            need = NEED_SOS;
        end else if (r_marker == MK_LSE) begin
            need = NEED_LSE;
        end else begin
            need = NEED_COM;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_marker    = r_marker;
        n_len       = r_len;
        n_pos       = r_pos;
        n_high      = r_high;
        n_scomp     = r_scomp;
        n_kind      = r_kind;
        n_frame     = r_frame;
        n_scan      = r_scan;
        n_preset    = r_preset;
        o_res       = '0;
        o_res_valid = 1'b0;
        clear       = 1'b0;
        advance     = 1'b0;
        if (i_valid) begin
            unique case (r_phase)
                PH_SOI_FF, PH_MARK_FF: begin
                    if (i_byte != MARK_BYTE) begin
                        o_res_valid  = 1'b1;
                        o_res.status = ST_INVALID;
                        clear        = 1'b1;
                    end else begin
                        n_phase = (r_phase == PH_SOI_FF) ? PH_SOI : PH_MARKER;
                    end
                end
                PH_SOI: begin
                    if (i_byte != MK_SOI) begin
                        o_res_valid  = 1'b1;
                        o_res.status = ST_INVALID;
                        clear        = 1'b1;
                    end else begin
                        n_phase = PH_MARK_FF;
                    end
                end
                PH_MARKER: begin
                    if (i_byte != MK_SOF && i_byte != MK_SOS && i_byte != MK_LSE &&
                        i_byte != MK_COM) begin
                        o_res_valid  = 1'b1;
                        o_res.status = ST_UNSUPPORTED;
                        clear        = 1'b1;
                    end else begin
                        n_marker = i_byte;
                        n_phase  = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    n_high  = i_byte;
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len = len_word;
                    n_pos = '0;
                    if (len_word < need) begin
                        o_res_valid  = 1'b1;
                        o_res.status = ST_SHORT;
                        clear        = 1'b1;
                    end else begin
                        n_phase = (len_word == NEED_COM) ? PH_MARK_FF : PH_BODY;
                    end
                end
                PH_BODY: begin
                    advance = 1'b1;
                    if (r_marker == MK_SOF) begin
                        if (r_pos < 16'd6) begin
                            unique case (r_pos[2:0])
                                3'd0:    n_frame[47:40] = i_byte;
                                3'd1:    n_frame[39:32] = i_byte;
                                3'd2:    n_frame[31:24] = i_byte;
                                3'd3:    n_frame[23:16] = i_byte;
                                3'd4:    n_frame[15:8]  = i_byte;
                                default: n_frame[7:0]   = i_byte;
                            endcase
                        end
                    end else if (r_marker == MK_LSE) begin
                        if (r_pos == 16'd0) begin
                            n_kind = i_byte;
                            if (i_byte == LSE_KIND_PRESET && r_len < NEED_PRESET) begin
                                o_res_valid  = 1'b1;
                                o_res.status = ST_SHORT;
                                clear        = 1'b1;
                                advance      = 1'b0;
                            end
                        end else if (r_kind == LSE_KIND_PRESET && r_pos <= LAST_PRESET_B) begin
                            if (r_pos[0]) begin
                                n_high = i_byte;
                            end else begin
                                n_preset[preset_idx] = {r_high, i_byte};
                            end
                        end
                    end else if (r_marker == MK_SOS) begin
                        if (r_pos == 16'd0) begin
                            n_scomp = i_byte;
                            if ({1'b0, r_len} < sos_need) begin
                                o_res_valid  = 1'b1;
                                o_res.status = ST_SHORT;
                                clear        = 1'b1;
                                advance      = 1'b0;
                            end
                        end else if ({1'b0, r_pos} == near_pos) begin
                            n_scan[15:8] = i_byte;
                        end else if ({1'b0, r_pos} == mode_pos) begin
                            o_res_valid           = 1'b1;
                            o_res.status          = ST_OK;
                            o_res.sample_bits     = r_frame[47:40];
                            o_res.image_height    = r_frame[39:24];
                            o_res.image_width     = r_frame[23:8];
                            o_res.component_count = r_frame[7:0];
                            o_res.near_limit      = r_scan[15:8];
                            o_res.interleave_mode = i_byte;
                            o_res.max_sample      = r_preset[0];
                            o_res.threshold_one   = r_preset[1];
                            o_res.threshold_two   = r_preset[2];
                            o_res.threshold_three = r_preset[3];
                            o_res.reset_interval  = r_preset[4];
                            clear                 = 1'b1;
                            advance               = 1'b0;
                        end
                    end
                    if (advance) begin
                        n_pos = pos_next;
                        if ({1'b0, pos_next} + 17'd2 >= {1'b0, r_len}) begin
                            n_phase = PH_MARK_FF;
                        end
                    end
                end
                default: begin
                    clear = 1'b1;
                end
            endcase
        end
        if (clear) begin
            n_phase  = PH_SOI_FF;
            n_marker = '0;
            n_len    = '0;
            n_pos    = '0;
            n_high   = '0;
            n_scomp  = '0;
            n_kind   = '0;
            n_frame  = '0;
            n_scan   = '0;
            for (int k = 0; k < PRESET_COUNT; k++) begin
                n_preset[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SOI_FF;
            r_marker <= '0;
            r_len    <= '0;
            r_pos    <= '0;
            r_high   <= '0;
            r_scomp  <= '0;
            r_kind   <= '0;
            r_frame  <= '0;
            r_scan   <= '0;
            for (int k = 0; k < PRESET_COUNT; k++) begin
                r_preset[k] <= '0;
            end
        end else begin
            r_phase  <= n_phase;
            r_marker <= n_marker;
            r_len    <= n_len;
            r_pos    <= n_pos;
            r_high   <= n_high;
            r_scomp  <= n_scomp;
            r_kind   <= n_kind;
            r_frame  <= n_frame;
            r_scan   <= n_scan;
            r_preset <= n_preset;
        end
    end

endmodule

`default_nettype wire

// File: hdl/jpegls_marker_header_parser.sv
// Top level of the JPEG-LS marker segment header parser with its input and result registers.
// The slave channel takes one stream byte per request in s_axis_tdata. The master channel
// gives at most one result per byte: the header fields in m_axis_tdata and the status code
// in m_axis_tuser. A result is given when the interleave byte of the SOS has been taken,
// or on the byte that shows bad framing, an unsupported marker or a short segment; after
// any result the parser starts again at the SOI marker.
// A byte is first held in an input register, is then parsed by the step logic, and its
// result lands in the output register; a stalled receiver can hold a byte in the input
// register before it is parsed. One byte is accepted in every cycle while the receiver
// does not stall; the rate is set by the state update of the parser core.
// The synchronous active-low reset returns the parser to the start of a stream and empties
// both registers. When the receiver stalls, the result waits in the output register and
// the input register can still take one more byte; further bytes are held off until the
// result is taken.
`default_nettype none

module jpegls_marker_header_parser (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           s_axis_tvalid,
    output logic          s_axis_tready,
    input  wire  [7:0]    s_axis_tdata,   // stream_byte
    output logic          m_axis_tvalid,
    input  wire           m_axis_tready,
    // sample_bits, image_height, image_width, component_count, near_limit,
    // interleave_mode, max_sample, threshold_one, threshold_two, threshold_three,
    // reset_interval
    output logic [143:0]  m_axis_tdata,
    output logic [1:0]    m_axis_tuser    // status
);
    import jlsmp_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_result     r_out_res;

    logic        step;
    logic        res_valid;
    t_result     res;

    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    jlsmp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (step),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (step) begin
                r_out_valid <= res_valid;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
        if (step && res_valid) begin
            r_out_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_res.status;
    assign m_axis_tdata  = {r_out_res.reset_interval,
                            r_out_res.threshold_three,
                            r_out_res.threshold_two,
                            r_out_res.threshold_one,
                            r_out_res.max_sample,
                            r_out_res.interleave_mode,
                            r_out_res.near_limit,
                            r_out_res.component_count,
                            r_out_res.image_width,
                            r_out_res.image_height,
                            r_out_res.sample_bits};

endmodule

`default_nettype wire

// File: verif/tb_jpegls_marker_header_parser.sv
// Self-checking testbench for the JPEG-LS marker segment header parser on its stream interfaces.
`default_nettype none

module tb_jpegls_marker_header_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import jlsmp_pkg::*;

    localparam int TOTAL_BYTES  = 1650;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DIR_ROWS     = 26;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       typed;
        t_status    status;
    } t_dir_row;

    logic           i_clk;
    logic           i_rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [7:0]     s_axis_tdata;   // stream_byte
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    // sample_bits, image_height, image_width, component_count, near_limit,
    // interleave_mode, max_sample, threshold_one, threshold_two, threshold_three,
    // reset_interval
    logic [143:0]   m_axis_tdata;
    logic [1:0]     m_axis_tuser;   // status

    t_phase         hdr_phase;
    logic [7:0]     hdr_marker;
    logic [15:0]    hdr_seg_len;
    logic [15:0]    hdr_seg_pos;
    logic [7:0]     hdr_high_byte;
    logic [7:0]     hdr_scan_comps;
    logic [7:0]     hdr_lse_kind;
    logic [47:0]    hdr_frame;
    logic [15:0]    hdr_scan;
    logic [15:0]    hdr_presets [PRESET_COUNT];

    t_result        expected_headers [$];
    logic [7:0]     stream_q [$];
    int             bytes_sent;
    int             results_expected;
    int             results_seen;
    int             headers_ok;
    int             headers_err;
    int             mismatches;
    int             cycle_count;
    bit             long_hold_done;

    // Error rows carry their status by hand; the rest are left to the predictor.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{8'h00, 1'b1, ST_INVALID},
        '{8'hFF, 1'b0, ST_OK},
        '{8'h00, 1'b1, ST_INVALID},
        '{8'hFF, 1'b0, ST_OK},
        '{MK_SOI, 1'b0, ST_OK},
        '{8'hFF, 1'b0, ST_OK},
        '{8'hFF, 1'b1, ST_UNSUPPORTED},
        '{8'hFF, 1'b0, ST_OK},
        '{MK_SOI, 1'b0, ST_OK},
        '{8'hFF, 1'b0, ST_OK},
        '{MK_SOF, 1'b0, ST_OK},
        '{8'h00, 1'b0, ST_OK},
        '{8'h07, 1'b1, ST_SHORT},
        '{8'hFF, 1'b0, ST_OK},
        '{MK_SOI, 1'b0, ST_OK},
        '{8'hFF, 1'b0, ST_OK},
        '{MK_COM, 1'b0, ST_OK},
        '{8'h00, 1'b0, ST_OK},
        '{8'h02, 1'b0, ST_OK},
        '{8'hFF, 1'b0, ST_OK},
        '{MK_SOS, 1'b0, ST_OK},
        '{8'h00, 1'b0, ST_OK},
        '{8'h05, 1'b0, ST_OK},
        '{8'h00, 1'b0, ST_OK},
        '{8'hFF, 1'b0, ST_OK},
        '{8'hFF, 1'b0, ST_OK}
    };

    jpegls_marker_header_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic void clear_header_state();
        hdr_phase      = PH_SOI_FF;
        hdr_marker     = '0;
        hdr_seg_len    = '0;
        hdr_seg_pos    = '0;
        hdr_high_byte  = '0;
        hdr_scan_comps = '0;
        hdr_lse_kind   = '0;
        hdr_frame      = '0;
        hdr_scan       = '0;
        for (int k = 0; k < PRESET_COUNT; k++) hdr_presets[k] = '0;
    endfunction

    function automatic bit parse_header_byte(input logic [7:0] b, output t_result r);
        int pos;
        int need;
        r = '0;
        case (hdr_phase)
            PH_SOI_FF, PH_MARK_FF: begin
                if (b != MARK_BYTE) begin
                    r.status = ST_INVALID;
                    clear_header_state();
                    return 1'b1;
                end
                hdr_phase = (hdr_phase == PH_SOI_FF) ? PH_SOI : PH_MARKER;
                return 1'b0;
            end
            PH_SOI: begin
                if (b != MK_SOI) begin
                    r.status = ST_INVALID;
                    clear_header_state();
                    return 1'b1;
                end
                hdr_phase = PH_MARK_FF;
                return 1'b0;
            end
            PH_MARKER: begin
                if (b != MK_SOF && b != MK_SOS && b != MK_LSE && b != MK_COM) begin
                    r.status = ST_UNSUPPORTED;
                    clear_header_state();
                    return 1'b1;
                end
                hdr_marker = b;
                hdr_phase  = PH_LEN_HI;
                return 1'b0;
            end
            PH_LEN_HI: begin
                hdr_high_byte = b;
                hdr_phase     = PH_LEN_LO;
                return 1'b0;
            end
            PH_LEN_LO: begin
                hdr_seg_len = {hdr_high_byte, b};
                hdr_seg_pos = '0;
                if (hdr_marker == MK_SOF) need = int'(NEED_SOF);
                else if (hdr_marker == MK_SOS) need = int'(NEED_SOS);
                else if (hdr_marker == MK_LSE) need = int'(NEED_LSE);
                else need = int'(NEED_COM);
                if (int'(hdr_seg_len) < need) begin
                    r.status = ST_SHORT;
                    clear_header_state();
                    return 1'b1;
                end
                hdr_phase = (hdr_seg_len == NEED_COM) ? PH_MARK_FF : PH_BODY;
                return 1'b0;
            end
            PH_BODY: begin
                pos = int'(hdr_seg_pos);
                if (hdr_marker == MK_SOF) begin
                    case (pos)
                        0: hdr_frame[47:40] = b;
                        1: hdr_frame[39:32] = b;
                        2: hdr_frame[31:24] = b;
                        3: hdr_frame[23:16] = b;
                        4: hdr_frame[15:8]  = b;
                        5: hdr_frame[7:0]   = b;
                        default: ;
                    endcase
                end else if (hdr_marker == MK_LSE) begin
                    if (pos == 0) begin
                        hdr_lse_kind = b;
                        if (b == LSE_KIND_PRESET && hdr_seg_len < NEED_PRESET) begin
                            r.status = ST_SHORT;
                            clear_header_state();
                            return 1'b1;
                        end
                    end else if (hdr_lse_kind == LSE_KIND_PRESET && pos <= int'(LAST_PRESET_B)) begin
                        if (((pos - 1) % 2) == 0) hdr_high_byte = b;
                        else hdr_presets[((pos - 1) / 2) % PRESET_COUNT] = {hdr_high_byte, b};
                    end
                end else if (hdr_marker == MK_SOS) begin
                    if (pos == 0) begin
                        hdr_scan_comps = b;
                        if (int'(hdr_seg_len) < 5 + 2 * int'(b)) begin
                            r.status = ST_SHORT;
                            clear_header_state();
                            return 1'b1;
                        end
                    end else if (pos == 1 + 2 * int'(hdr_scan_comps)) begin
                        hdr_scan[15:8] = b;
                    end else if (pos == 2 + 2 * int'(hdr_scan_comps)) begin
                        hdr_scan[7:0]     = b;
                        r.status          = ST_OK;
                        r.sample_bits     = hdr_frame[47:40];
                        r.image_height    = hdr_frame[39:24];
                        r.image_width     = hdr_frame[23:8];
                        r.component_count = hdr_frame[7:0];
                        r.near_limit      = hdr_scan[15:8];
                        r.interleave_mode = hdr_scan[7:0];
                        r.max_sample      = hdr_presets[0];
                        r.threshold_one   = hdr_presets[1];
                        r.threshold_two   = hdr_presets[2];
                        r.threshold_three = hdr_presets[3];
                        r.reset_interval  = hdr_presets[4];
                        clear_header_state();
                        return 1'b1;
                    end
                end
                hdr_seg_pos = 16'(pos + 1);
                if (int'(hdr_seg_pos) + 2 >= int'(hdr_seg_len)) hdr_phase = PH_MARK_FF;
                return 1'b0;
            end
            default: begin
                clear_header_state();
                return 1'b0;
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Leaves the request on the bus until it is taken, then records what it should produce.
    task automatic offer_byte(input logic [7:0] b, input int gap, input bit typed,
                              input t_status st);
        t_result r;
        bit      made;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        made = parse_header_byte(b, r);
        if (typed) begin
            made     = 1'b1;
            r        = '0;
            r.status = st;
        end
        if (made) begin
            expected_headers = {expected_headers, r};
            results_expected++;
        end
        bytes_sent++;
    endtask

    task automatic append_byte(input logic [7:0] b);
        stream_q = {stream_q, b};
    endtask

    task automatic push_word(input int w);
        append_byte(8'(w >> 8));
        append_byte(8'(w));
    endtask

    task automatic push_random(input int n);
        for (int k = 0; k < n; k++) append_byte(8'($urandom_range(0, 255)));
    endtask

    // Mostly well-formed headers with random contents; the rest is noise or a broken segment.
    task automatic build_stream();
        int         segs;
        int         len;
        int         comps;
        int         extra;
        int         need;
        logic [7:0] m;
        stream_q.delete();
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6)) begin
                append_byte(($urandom_range(0, 3) == 0) ? MARK_BYTE
                                                        : 8'($urandom_range(0, 255)));
            end
            return;
        end
        append_byte(MARK_BYTE);
        append_byte(($urandom_range(0, 29) == 0) ? 8'($urandom_range(0, 255)) : MK_SOI);
        segs = $urandom_range(0, 4);
        for (int s = 0; s < segs; s++) begin
            if ($urandom_range(0, 14) == 0) begin
                case ($urandom_range(0, 3))
                    0: append_byte(8'($urandom_range(0, 254)));
                    1: begin
                        append_byte(MARK_BYTE);
                        do m = 8'($urandom_range(0, 255));
                        while (m == MK_SOF || m == MK_SOS || m == MK_LSE || m == MK_COM);
                        append_byte(m);
                    end
                    2: begin
                        case ($urandom_range(0, 3))
                            0: begin m = MK_SOF; need = int'(NEED_SOF); end
                            1: begin m = MK_SOS; need = int'(NEED_SOS); end
                            2: begin m = MK_LSE; need = int'(NEED_LSE); end
                            default: begin m = MK_COM; need = int'(NEED_COM); end
                        endcase
                        append_byte(MARK_BYTE);
                        append_byte(m);
                        push_word($urandom_range(0, need - 1));
                    end
                    default: begin
                        append_byte(MARK_BYTE);
                        append_byte(MK_LSE);
                        push_word($urandom_range(int'(NEED_LSE), int'(NEED_PRESET) - 1));
                        append_byte(LSE_KIND_PRESET);
                    end
                endcase
                return;
            end
            append_byte(MARK_BYTE);
            case ($urandom_range(0, 3))
                0: begin
                    len = 8 + (($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0);
                    append_byte(MK_SOF);
                    push_word(len);
                    push_random(len - 2);
                end
                1: begin
                    len = 13 + (($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
                    append_byte(MK_LSE);
                    push_word(len);
                    append_byte(LSE_KIND_PRESET);
                    push_random(len - 3);
                end
                2: begin
                    len = $urandom_range(3, 8);
                    append_byte(MK_LSE);
                    push_word(len);
                    m = 8'($urandom_range(0, 255));
                    append_byte((m == LSE_KIND_PRESET) ? 8'h00 : m);
                    push_random(len - 3);
                end
                default: begin
                    len = ($urandom_range(0, 19) == 0) ? $urandom_range(2, 400)
                                                       : $urandom_range(2, 8);
                    append_byte(MK_COM);
                    push_word(len);
                    push_random(len - 2);
                end
            endcase
        end
        comps = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: extra = 0;
            6, 7:             extra = $urandom_range(1, 3);
            default:          extra = $urandom_range(0, 65535 - 5 - 2 * comps);
        endcase
        len = 5 + 2 * comps + extra;
        append_byte(MARK_BYTE);
        append_byte(MK_SOS);
        if (comps > 0 && $urandom_range(0, 14) == 0) begin
            push_word($urandom_range(5, 4 + 2 * comps));
            append_byte(8'(comps));
            return;
        end
        push_word(len);
        append_byte(8'(comps));
        push_random(2 * comps + 2);
        if (extra > 0 && $urandom_range(0, 4) == 0) push_random($urandom_range(1, 3));
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status          = t_status'(m_axis_tuser);
            got.sample_bits     = m_axis_tdata[7:0];
            got.image_height    = m_axis_tdata[23:8];
            got.image_width     = m_axis_tdata[39:24];
            got.component_count = m_axis_tdata[47:40];
            got.near_limit      = m_axis_tdata[55:48];
            got.interleave_mode = m_axis_tdata[63:56];
            got.max_sample      = m_axis_tdata[79:64];
            got.threshold_one   = m_axis_tdata[95:80];
            got.threshold_two   = m_axis_tdata[111:96];
            got.threshold_three = m_axis_tdata[127:112];
            got.reset_interval  = m_axis_tdata[143:128];
            results_seen++;
            if (expected_headers.size() == 0) begin
                $error("result with status %0d arrived with none outstanding", m_axis_tuser);
                mismatches++;
            end else begin
                want = expected_headers.pop_front();
                if (want.status == ST_OK) headers_ok++;
                else headers_err++;
                check_field("status", 16'(want.status), 16'(got.status));
                check_field("sample_bits", 16'(want.sample_bits), 16'(got.sample_bits));
                check_field("image_height", want.image_height, got.image_height);
                check_field("image_width", want.image_width, got.image_width);
                check_field("component_count", 16'(want.component_count),
                            16'(got.component_count));
                check_field("near_limit", 16'(want.near_limit), 16'(got.near_limit));
                check_field("interleave_mode", 16'(want.interleave_mode),
                            16'(got.interleave_mode));
                check_field("max_sample", want.max_sample, got.max_sample);
                check_field("threshold_one", want.threshold_one, got.threshold_one);
                check_field("threshold_two", want.threshold_two, got.threshold_two);
                check_field("threshold_three", want.threshold_three, got.threshold_three);
                check_field("reset_interval", want.reset_interval, got.reset_interval);
            end
        end
    end

    // The long hold lets the block fill up and push back on the sender.
    initial begin : result_receiver
        m_axis_tready = 1'b0;
        repeat (12) @(posedge i_clk);
        forever begin
            if (!long_hold_done && results_seen >= 20) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_done = 1'b1;
            end else if ($urandom_range(0, 9) < 6) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 3)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("jpegls_marker_header_parser verification failed");
            $finish;
        end
    end

    initial begin : stream_sender
        bit burst;
        i_rst_n          = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        bytes_sent       = 0;
        results_expected = 0;
        results_seen     = 0;
        headers_ok       = 0;
        headers_err      = 0;
        mismatches       = 0;
        long_hold_done   = 1'b0;
        clear_header_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++) begin
            offer_byte(dir_rows[k].stream_byte, 0, dir_rows[k].typed, dir_rows[k].status);
        end

        while (bytes_sent < TOTAL_BYTES) begin
            build_stream();
            burst = ($urandom_range(0, 3) == 0);
            foreach (stream_q[k]) offer_byte(stream_q[k], burst ? 0 : pick_gap(), 1'b0, ST_OK);
        end
        s_axis_tvalid <= 1'b0;

        while (expected_headers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d stream bytes; checked %0d headers and %0d error results.",
                 bytes_sent, headers_ok, headers_err);
        $display("Receiver held off for %0d cycles once while requests kept coming.",
                 LONG_HOLD);
        if (mismatches == 0) begin
            $display("jpegls_marker_header_parser verification clean");
        end else begin
            $display("jpegls_marker_header_parser verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
hdl/jlsmp_pkg.sv
hdl/jlsmp_core.sv
hdl/jpegls_marker_header_parser.sv
verif/tb_jpegls_marker_header_parser.sv
